FILE: sv/xeex_pkg.sv
// Package for the XML empty-element expander.
// Holds sizes, character codes, output select codes and the control/status structs.
// No dependencies.
package xeex_pkg;

  localparam int NAME_BYTES = 31;
  localparam int LEN_W = $clog2(NAME_BYTES + 1);
  localparam int IDX_W = (NAME_BYTES > 1) ? $clog2(NAME_BYTES) : 1;

  localparam logic [7:0] CH_LT    = 8'h3C;  // '<'
  localparam logic [7:0] CH_GT    = 8'h3E;  // '>'
  localparam logic [7:0] CH_SLASH = 8'h2F;  // '/'
  localparam logic [7:0] CH_SPACE = 8'h20;  // ' '

  // output byte select
  localparam logic [2:0] SEL_IN    = 3'd0;
  localparam logic [2:0] SEL_SLASH = 3'd1;
  localparam logic [2:0] SEL_LT    = 3'd2;
  localparam logic [2:0] SEL_GT    = 3'd3;
  localparam logic [2:0] SEL_NAME  = 3'd4;
  localparam logic [2:0] SEL_PEND  = 3'd5;

  typedef struct packed {
    logic       load;       // write the output register
    logic [2:0] sel;
    logic       run_last;
    logic       sec_end;
    logic       trunc_en;   // flag the word with the name's truncation bit
    logic       upd_norm;   // apply ordinary byte handling to the name state
    logic       clr_hold;
    logic       exp_start;
    logic       exp_done;
    logic       idx_inc;
    logic       end_clear;
    logic       pend_cap;
  } ctrl_cmd_t;

  typedef struct packed {
    logic out_free;
    logic held;
    logic collecting;
    logic is_gt;
    logic is_sl;
    logic len_nz;
    logic sec_end;
    logic idx_last;
  } dp_status_t;

endpackage

FILE: sv/xeex_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module xeex_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                                        clk_i,
  input  logic                                        we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                            wdata_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                            rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

FILE: sv/xeex_dp.sv
// Datapath: name state, name RAM, replay index, pending byte and output register.
// Depends on xeex_pkg and xeex_ram.
module xeex_dp
  import xeex_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic [7:0] data_byte_i,
  input  logic       section_end_i,
  input  logic       out_stall_i,
  input  ctrl_cmd_t  cmd_i,
  output dp_status_t st_o,
  output logic       out_valid_o,
  output logic [7:0] out_byte_o,
  output logic       run_last_o,
  output logic       out_section_end_o,
  output logic       name_truncated_o
);

  logic [LEN_W-1:0] len_q, len_d;
  logic             coll_q, coll_d;
  logic             held_q, held_d;
  logic             trunc_q, trunc_d;
  logic [IDX_W-1:0] idx_q, idx_d;
  logic [7:0]       pend_q;
  logic             ov_q;
  logic [7:0]       ob_q;
  logic             orl_q, oend_q, otr_q;
  logic [7:0]       rdata;
  logic [7:0]       byte_mux;
  logic             is_gt, is_lt, is_sp, is_sl, len_full, len_nz, name_we;

  assign is_gt    = (data_byte_i == CH_GT);
  assign is_lt    = (data_byte_i == CH_LT);
  assign is_sp    = (data_byte_i == CH_SPACE);
  assign is_sl    = (data_byte_i == CH_SLASH);
  assign len_full = (len_q == LEN_W'(NAME_BYTES));
  assign len_nz   = (len_q != '0);
  assign name_we  = cmd_i.upd_norm && coll_q && !is_sp && !is_gt && !len_full;

  always_comb begin
    len_d   = len_q;
    coll_d  = coll_q;
    held_d  = held_q;
    trunc_d = trunc_q;
    if (cmd_i.upd_norm) begin
      held_d = !coll_q && !is_lt && is_sl && len_nz && !section_end_i;
      if (coll_q) begin
        if (is_sp) begin
          coll_d = 1'b0;
        end else if (is_gt) begin
          coll_d = 1'b0;
          len_d  = '0;
        end else if (!len_full) begin
          len_d = len_q + 1'b1;
        end else begin
          trunc_d = 1'b1;
        end
      end else if (is_lt) begin
        coll_d  = 1'b1;
        len_d   = '0;
        trunc_d = 1'b0;
      end
    end
    if (cmd_i.clr_hold) begin
      held_d = 1'b0;
    end
    if (cmd_i.exp_done) begin
      len_d = '0;
    end
    if (cmd_i.end_clear) begin
      len_d   = '0;
      coll_d  = 1'b0;
      held_d  = 1'b0;
      trunc_d = 1'b0;
    end
  end

  // read address is the next index so that rdata always shows name[idx_q]
  always_comb begin
    idx_d = idx_q;
    if (cmd_i.exp_start) begin
      idx_d = '0;
    end else if (cmd_i.idx_inc) begin
      idx_d = idx_q + 1'b1;
    end
  end

  xeex_ram #(
    .WIDTH(8),
    .DEPTH(NAME_BYTES)
  ) u_name_ram (
    .clk_i  (clk_i),
    .we_i   (name_we),
    .waddr_i(len_q[IDX_W-1:0]),
    .wdata_i(data_byte_i),
    .raddr_i(idx_d),
    .rdata_o(rdata)
  );

  always_comb begin
    case (cmd_i.sel)
      SEL_IN:    byte_mux = data_byte_i;
      SEL_SLASH: byte_mux = CH_SLASH;
      SEL_LT:    byte_mux = CH_LT;
      SEL_GT:    byte_mux = CH_GT;
      SEL_NAME:  byte_mux = rdata;
      SEL_PEND:  byte_mux = pend_q;
      default:   byte_mux = data_byte_i;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q   <= '0;
      coll_q  <= 1'b0;
      held_q  <= 1'b0;
      trunc_q <= 1'b0;
      idx_q   <= '0;
      ov_q    <= 1'b0;
    end else begin
      len_q   <= len_d;
      coll_q  <= coll_d;
      held_q  <= held_d;
      trunc_q <= trunc_d;
      idx_q   <= idx_d;
      if (cmd_i.load) begin
        ov_q <= 1'b1;
      end else if (!out_stall_i) begin
        ov_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.pend_cap) begin
      pend_q <= data_byte_i;
    end
    if (cmd_i.load) begin
      ob_q   <= byte_mux;
      orl_q  <= cmd_i.run_last;
      oend_q <= cmd_i.sec_end;
      otr_q  <= cmd_i.trunc_en && trunc_q;
    end
  end

  assign st_o.out_free   = !ov_q || !out_stall_i;
  assign st_o.held       = held_q;
  assign st_o.collecting = coll_q;
  assign st_o.is_gt      = is_gt;
  assign st_o.is_sl      = is_sl;
  assign st_o.len_nz     = len_nz;
  assign st_o.sec_end    = section_end_i;
  assign st_o.idx_last   = ((LEN_W'(idx_q) + 1'b1) == len_q);

  assign out_valid_o       = ov_q;
  assign out_byte_o        = ob_q;
  assign run_last_o        = orl_q;
  assign out_section_end_o = oend_q;
  assign name_truncated_o  = otr_q;

endmodule

FILE: sv/xeex_ctrl.sv
// Controller: accepts input words and sequences the expansion replay.
// Depends on xeex_pkg.
module xeex_ctrl
  import xeex_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  dp_status_t st_i,
  output ctrl_cmd_t  cmd_o
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_PEND = 3'd1;
  localparam logic [2:0] S_LT   = 3'd2;
  localparam logic [2:0] S_SL   = 3'd3;
  localparam logic [2:0] S_NAME = 3'd4;
  localparam logic [2:0] S_GT   = 3'd5;

  logic [2:0] state_q, state_d;
  logic       end_q, end_d;
  logic       norm_emit;

  // ordinary handling emits the byte unless it is a '/' that gets held
  assign norm_emit = st_i.collecting || !(st_i.is_sl && st_i.len_nz && !st_i.sec_end);

  always_comb begin
    cmd_o      = '0;
    cmd_o.sel  = SEL_IN;
    state_d    = state_q;
    end_d      = end_q;
    in_stall_o = 1'b1;
    case (state_q)
      S_IDLE: begin
        in_stall_o = !st_i.out_free;
        if (in_valid_i && st_i.out_free) begin
          if (st_i.held && st_i.is_gt) begin
            cmd_o.load      = 1'b1;
            cmd_o.sel       = SEL_GT;
            cmd_o.trunc_en  = 1'b1;
            cmd_o.clr_hold  = 1'b1;
            cmd_o.exp_start = 1'b1;
            end_d           = st_i.sec_end;
            state_d         = S_LT;
          end else if (st_i.held) begin
            cmd_o.load      = 1'b1;
            cmd_o.sel       = SEL_SLASH;
            cmd_o.run_last  = !norm_emit;
            cmd_o.sec_end   = !norm_emit && st_i.sec_end;
            cmd_o.upd_norm  = 1'b1;
            cmd_o.end_clear = st_i.sec_end;
            if (norm_emit) begin
              cmd_o.pend_cap = 1'b1;
              end_d          = st_i.sec_end;
              state_d        = S_PEND;
            end
          end else begin
            cmd_o.load      = norm_emit;
            cmd_o.sel       = SEL_IN;
            cmd_o.run_last  = 1'b1;
            cmd_o.sec_end   = st_i.sec_end;
            cmd_o.upd_norm  = 1'b1;
            cmd_o.end_clear = st_i.sec_end;
          end
        end
      end
      S_PEND: begin
        if (st_i.out_free) begin
          cmd_o.load     = 1'b1;
          cmd_o.sel      = SEL_PEND;
          cmd_o.run_last = 1'b1;
          cmd_o.sec_end  = end_q;
          state_d        = S_IDLE;
        end
      end
      S_LT: begin
        if (st_i.out_free) begin
          cmd_o.load     = 1'b1;
          cmd_o.sel      = SEL_LT;
          cmd_o.trunc_en = 1'b1;
          state_d        = S_SL;
        end
      end
      S_SL: begin
        if (st_i.out_free) begin
          cmd_o.load     = 1'b1;
          cmd_o.sel      = SEL_SLASH;
          cmd_o.trunc_en = 1'b1;
          state_d        = S_NAME;
        end
      end
      S_NAME: begin
        if (st_i.out_free) begin
          cmd_o.load     = 1'b1;
          cmd_o.sel      = SEL_NAME;
          cmd_o.trunc_en = 1'b1;
          cmd_o.idx_inc  = 1'b1;
          if (st_i.idx_last) begin
            state_d = S_GT;
          end
        end
      end
      S_GT: begin
        if (st_i.out_free) begin
          cmd_o.load      = 1'b1;
          cmd_o.sel       = SEL_GT;
          cmd_o.trunc_en  = 1'b1;
          cmd_o.run_last  = 1'b1;
          cmd_o.sec_end   = end_q;
          cmd_o.exp_done  = 1'b1;
          cmd_o.end_clear = end_q;
          state_d         = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      end_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      end_q   <= end_d;
    end
  end

endmodule

FILE: sv/xml_empty_element_expander.sv
// Top level of the XML empty-element expander.
// Depends on xeex_pkg, xeex_ctrl, xeex_dp (which holds xeex_ram).
//
// Input channel: in_valid_i / in_stall_o carry one raw byte (data_byte_i)
// plus section_end_i on the last byte of a section. Output channel:
// out_valid_o / out_stall_i carry one canonical byte per word with
// run_last_o, out_section_end_o and name_truncated_o.
// A word moves when valid is high and stall is low.
//
// A byte's first word is offered in the cycle after it is taken. Ordinary
// bytes pass at one per cycle unless the receiver stalls; the output
// register is reloaded in the same cycle it drains. After a held '/',
// another byte emits the '/' and is handled as usual. A "/>" expansion
// gives 4 + name length words (up to 35), at the same rate, from the replay
// sequencer reading the name RAM; it stalls the input until done. A '/'
// that may start "/>" produces no word until the next byte arrives.
//
// Reset clears the name length, collect, held-slash and truncation state;
// the name RAM needs no clearing since only written entries are replayed.
// When the receiver stalls, the output word holds and input is stalled.
module xml_empty_element_expander
  import xeex_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] data_byte_i,
  input  logic       section_end_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [7:0] out_byte_o,
  output logic       run_last_o,
  output logic       out_section_end_o,
  output logic       name_truncated_o
);

  ctrl_cmd_t  cmd;
  dp_status_t st;

  xeex_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(in_valid_i),
    .in_stall_o(in_stall_o),
    .st_i      (st),
    .cmd_o     (cmd)
  );

  xeex_dp u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .data_byte_i      (data_byte_i),
    .section_end_i    (section_end_i),
    .out_stall_i      (out_stall_i),
    .cmd_i            (cmd),
    .st_o             (st),
    .out_valid_o      (out_valid_o),
    .out_byte_o       (out_byte_o),
    .run_last_o       (run_last_o),
    .out_section_end_o(out_section_end_o),
    .name_truncated_o (name_truncated_o)
  );

  // an input word is taken only when the output register can take its result
  a_accept_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |-> (!out_valid_o || !out_stall_i))
    else $error("input accepted while output register blocked");

  a_end_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_section_end_o) |-> run_last_o)
    else $error("section end on a word that is not the last of its run");

  a_stall_keeps: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> (out_valid_o && $stable(out_byte_o)))
    else $error("stalled output word lost or changed");

endmodule

FILE: tb/sv/tb_top.sv
// Testbench for xml_empty_element_expander: drives byte runs over the valid/stall input,
// predicts the canonical output words and checks each word as it leaves the block.
// Depends on xeex_pkg and the expander RTL.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import xeex_pkg::*;

  localparam int IDLE_LIMIT  = 2000;  // cycles with no word moved on either side
  localparam int HOLD_CYCLES = 300;
  localparam int TAIL_CYCLES = 40;    // longest expansion plus margin
  localparam int TOTAL_ITEMS = 320;

  typedef struct packed {
    logic [7:0] data;
    logic       run_last;
    logic       sec_end;
    logic       trunc;
  } canon_word_t;

  typedef enum logic [2:0] {
    FRAG_EMPTY_ATTR,   // <name attr/>  -> expanded
    FRAG_EMPTY_BARE,   // <name/>       -> left alone
    FRAG_OPEN_CLOSE,   // <name>text</name>
    FRAG_EMPTY_NAME,   // < attr/>
    FRAG_TEXT,
    FRAG_NOISE,
    FRAG_BROKEN        // held slash not followed by '>'
  } frag_kind_e;

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       in_valid_i = 1'b0;
  logic       in_stall_o;
  logic [7:0] data_byte_i = 8'h00;
  logic       section_end_i = 1'b0;
  logic       out_valid_o;
  logic       out_stall_i = 1'b0;
  logic [7:0] out_byte_o;
  logic       run_last_o;
  logic       out_section_end_o;
  logic       name_truncated_o;

  always #1 clk_i = ~clk_i;

  xml_empty_element_expander u_top (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_valid_i),
    .in_stall_o        (in_stall_o),
    .data_byte_i       (data_byte_i),
    .section_end_i     (section_end_i),
    .out_valid_o       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .out_byte_o        (out_byte_o),
    .run_last_o        (run_last_o),
    .out_section_end_o (out_section_end_o),
    .name_truncated_o  (name_truncated_o)
  );

  // Predictor state
  canon_word_t canon_q[$];
  logic [7:0]  name_buf[NAME_BYTES];
  int          name_len = 0;
  bit          collecting = 1'b0;
  bit          slash_pend = 1'b0;
  bit          name_cut = 1'b0;

  int err_count = 0;
  int n_sent = 0;
  int words_seen = 0;
  int tx_max_gap = 10;
  int rx_max_gap = 10;
  bit hold_req = 1'b0;

  task automatic report_error(input string msg);
    $display("ERROR word %0d: %s", words_seen, msg);
    err_count++;
  endtask

  function automatic canon_word_t mk_word(input logic [7:0] d, input bit t);
    canon_word_t w;
    w.data = d;
    w.run_last = 1'b0;
    w.sec_end = 1'b0;
    w.trunc = t;
    return w;
  endfunction

  // Works out the words one accepted byte causes and queues them.
  function automatic void canon_step(input logic [7:0] b, input bit sec_end);
    canon_word_t run[$];
    bit done;
    int i;
    done = 1'b0;
    if (slash_pend) begin
      slash_pend = 1'b0;
      if (b == CH_GT) begin
        run.push_back(mk_word(CH_GT, name_cut));
        run.push_back(mk_word(CH_LT, name_cut));
        run.push_back(mk_word(CH_SLASH, name_cut));
        for (i = 0; i < name_len; i++) run.push_back(mk_word(name_buf[i], name_cut));
        run.push_back(mk_word(CH_GT, name_cut));
        name_len = 0;
        done = 1'b1;
      end else begin
        run.push_back(mk_word(CH_SLASH, 1'b0));
      end
    end
    if (!done) begin
      if (collecting) begin
        if (b == CH_SPACE) begin
          collecting = 1'b0;
        end else if (b == CH_GT) begin
          collecting = 1'b0;
          name_len = 0;
        end else if (name_len < NAME_BYTES) begin
          name_buf[name_len] = b;
          name_len++;
        end else begin
          name_cut = 1'b1;
        end
        run.push_back(mk_word(b, 1'b0));
      end else if (b == CH_LT) begin
        collecting = 1'b1;
        name_len = 0;
        name_cut = 1'b0;
        run.push_back(mk_word(b, 1'b0));
      end else if (b == CH_SLASH && name_len > 0 && !sec_end) begin
        slash_pend = 1'b1;
      end else begin
        run.push_back(mk_word(b, 1'b0));
      end
    end
    if (sec_end) begin
      name_len = 0;
      collecting = 1'b0;
      slash_pend = 1'b0;
      name_cut = 1'b0;
    end
    if (run.size() > 0) begin
      run[run.size() - 1].run_last = 1'b1;
      run[run.size() - 1].sec_end = sec_end;
    end
    foreach (run[k]) canon_q.push_back(run[k]);
  endfunction

  // Offers one word and returns at the edge that takes it.
  task automatic send_byte(input logic [7:0] b, input bit last);
    int gap;
    bit took;
    gap = $urandom_range(0, tx_max_gap);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    data_byte_i <= b;
    section_end_i <= last;
    do begin
      @(negedge clk_i);
      took = !in_stall_o;
      @(posedge clk_i);
    end while (!took);
    canon_step(b, last);
    n_sent++;
  endtask

  task automatic wait_results_drained();
    in_valid_i <= 1'b0;
    while (canon_q.size() != 0) @(posedge clk_i);
    // a held slash gives no word, so leave the block time to settle
    repeat (TAIL_CYCLES) @(posedge clk_i);
  endtask

  function automatic logic [7:0] name_char();
    logic [7:0] c;
    do c = 8'($urandom); while (c == CH_SPACE || c == CH_GT);
    return c;
  endfunction

  function automatic logic [7:0] attr_char();
    logic [7:0] c;
    do c = 8'($urandom_range(33, 126)); while (c == CH_LT || c == CH_SLASH || c == CH_GT);
    return c;
  endfunction

  function automatic logic [7:0] text_char();
    logic [7:0] c;
    do c = 8'($urandom); while (c == CH_LT);
    return c;
  endfunction

  function automatic frag_kind_e pick_kind();
    case ($urandom_range(0, 11))
      0, 1, 2, 3: return FRAG_EMPTY_ATTR;
      4:          return FRAG_EMPTY_BARE;
      5, 6:       return FRAG_OPEN_CLOSE;
      7:          return FRAG_EMPTY_NAME;
      8:          return FRAG_TEXT;
      9:          return FRAG_NOISE;
      default:    return FRAG_BROKEN;
    endcase
  endfunction

  // Builds one markup fragment; nlen <= 0 picks a name length, mostly short.
  task automatic send_fragment(input frag_kind_e kind, input int nlen);
    logic [7:0] name[$];
    logic [7:0] run[$];
    logic [7:0] c;
    bit end_last;
    if (nlen <= 0)
      nlen = ($urandom_range(0, 9) == 0) ? $urandom_range(28, 40) : $urandom_range(1, 6);
    repeat (nlen) name.push_back(name_char());
    end_last = ($urandom_range(0, 4) == 0);
    case (kind)
      FRAG_EMPTY_ATTR, FRAG_EMPTY_NAME, FRAG_BROKEN: begin
        run.push_back(CH_LT);
        if (kind != FRAG_EMPTY_NAME) foreach (name[i]) run.push_back(name[i]);
        run.push_back(CH_SPACE);
        repeat ($urandom_range(1, 5)) run.push_back(attr_char());
        if ($urandom_range(0, 1) == 1) run.push_back(CH_SPACE);
        run.push_back(CH_SLASH);
        if (kind != FRAG_BROKEN) begin
          run.push_back(CH_GT);
        end else if ($urandom_range(0, 1) == 1) begin
          run.push_back(CH_SLASH);
          run.push_back(CH_GT);
        end else begin
          do c = 8'($urandom); while (c == CH_GT);
          run.push_back(c);
        end
      end
      FRAG_EMPTY_BARE: begin
        run.push_back(CH_LT);
        foreach (name[i]) run.push_back(name[i]);
        run.push_back(CH_SLASH);
        run.push_back(CH_GT);
      end
      FRAG_OPEN_CLOSE: begin
        run.push_back(CH_LT);
        foreach (name[i]) run.push_back(name[i]);
        run.push_back(CH_GT);
        repeat ($urandom_range(0, 4)) run.push_back(text_char());
        run.push_back(CH_LT);
        run.push_back(CH_SLASH);
        foreach (name[i]) run.push_back(name[i]);
        run.push_back(CH_GT);
      end
      FRAG_TEXT: begin
        repeat ($urandom_range(1, 8)) run.push_back(text_char());
      end
      default: begin
        // noise: any byte, section end anywhere
        repeat ($urandom_range(1, 6)) send_byte(8'($urandom), $urandom_range(0, 7) == 0);
      end
    endcase
    foreach (run[i]) send_byte(run[i], end_last && (i == run.size() - 1));
  endtask

  task automatic test_directed();
    // held slash followed by another slash, then expansion; extreme name byte
    send_byte(CH_LT, 1'b0);  send_byte(8'hFF, 1'b0);     send_byte(CH_SPACE, 1'b0);
    send_byte(CH_SLASH, 1'b0); send_byte(CH_SLASH, 1'b0); send_byte(CH_GT, 1'b0);
    // slash on the section's last byte goes straight out
    send_byte(CH_LT, 1'b0);  send_byte(8'h00, 1'b0);     send_byte(CH_SPACE, 1'b0);
    send_byte(CH_SLASH, 1'b1);
    // "<a/>": slash is part of the name, no expansion
    send_byte(CH_LT, 1'b0);  send_byte("a", 1'b0);       send_byte(CH_SLASH, 1'b0);
    send_byte(CH_GT, 1'b0);
    // empty name never expands
    send_byte(CH_LT, 1'b0);  send_byte(CH_SPACE, 1'b0);  send_byte(CH_SLASH, 1'b0);
    send_byte(CH_GT, 1'b0);
    // held slash flushed by a section end on a plain byte
    send_byte(CH_LT, 1'b0);  send_byte("b", 1'b0);       send_byte(CH_SPACE, 1'b0);
    send_byte(CH_SLASH, 1'b0); send_byte("z", 1'b1);
  endtask

  task automatic test_bursts();
    int stop_at;
    stop_at = n_sent + 80;
    tx_max_gap = 0;
    rx_max_gap = 0;
    while (n_sent < stop_at) send_fragment(pick_kind(), 0);
    tx_max_gap = 10;
    rx_max_gap = 10;
  endtask

  // Receiver stops for a long stretch while input keeps coming, so the block backs up.
  task automatic test_output_holdoff();
    hold_req = 1'b1;
    tx_max_gap = 0;
    repeat (6) send_fragment(FRAG_EMPTY_ATTR, 0);
    tx_max_gap = 10;
  endtask

  task automatic test_long_names();
    send_fragment(FRAG_EMPTY_ATTR, NAME_BYTES);
    send_fragment(FRAG_EMPTY_ATTR, NAME_BYTES + 1);
    send_fragment(FRAG_EMPTY_ATTR, 40);
  endtask

  task automatic test_random_mix();
    while (n_sent < TOTAL_ITEMS) begin
      if ($urandom_range(0, 3) == 0) begin
        tx_max_gap = 0;
        rx_max_gap = 0;
      end else begin
        tx_max_gap = 10;
        rx_max_gap = 10;
      end
      send_fragment(pick_kind(), 0);
    end
    tx_max_gap = 10;
    rx_max_gap = 10;
  endtask

  // Receiver side: random stall before each word, plus the long hold when asked.
  initial begin : rx_side
    int gap;
    bit took;
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        out_stall_i <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk_i);
      end
      gap = $urandom_range(0, rx_max_gap);
      out_stall_i <= (gap != 0);
      repeat (gap) @(posedge clk_i);
      if (gap != 0) out_stall_i <= 1'b0;
      do begin
        @(negedge clk_i);
        took = out_valid_o;
        @(posedge clk_i);
      end while (!took);
    end
  end

  // Outputs are stable between edges; sample mid-cycle for the coming edge.
  initial begin : word_checker
    canon_word_t want;
    wait (rst_ni);
    forever begin
      @(negedge clk_i);
      if (out_valid_o && !out_stall_i) begin
        if (canon_q.size() == 0) begin
          report_error($sformatf("unexpected word %02h", out_byte_o));
        end else begin
          want = canon_q.pop_front();
          if (out_byte_o !== want.data)
            report_error($sformatf("out_byte %02h, expected %02h", out_byte_o, want.data));
          if (run_last_o !== want.run_last)
            report_error($sformatf("run_last %b, expected %b", run_last_o, want.run_last));
          if (out_section_end_o !== want.sec_end)
            report_error($sformatf("out_section_end %b, expected %b",
                                   out_section_end_o, want.sec_end));
          if (name_truncated_o !== want.trunc)
            report_error($sformatf("name_truncated %b, expected %b",
                                   name_truncated_o, want.trunc));
        end
        words_seen++;
      end
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < IDLE_LIMIT) begin
      @(negedge clk_i);
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) quiet = 0;
      else quiet++;
    end
    $display("simulation failed");
    $finish;
  end

  initial begin
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    wait_results_drained();
    test_bursts();
    test_output_holdoff();
    wait_results_drained();
    test_long_names();
    test_random_mix();
    wait_results_drained();
    if (err_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

FILE: sim.f
sv/xeex_pkg.sv
sv/xeex_ram.sv
sv/xeex_dp.sv
sv/xeex_ctrl.sv
sv/xml_empty_element_expander.sv
tb/sv/tb_top.sv
